// ===== hw/rtl/des_block_cipher_top_defines.svh =====
// assertion macros for the des block cipher top level
// expects clk_i and rst_ni in the scope of use
`ifndef DES_BLOCK_CIPHER_TOP_DEFINES_SVH
`define DES_BLOCK_CIPHER_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define DES_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("des check failed");

// antecedent implies consequent in the next cycle
`define DES_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("des check failed");

`endif

// ===== hw/rtl/des_pkg.sv =====
// des package: stage type, permutation tables, s-boxes and round functions
// used by des_key_sched, des_round_cell and des_block_cipher_top
`default_nettype none

package des_pkg;

  localparam int unsigned NumRounds = 16;

  typedef logic [47:0] rkey_t;

  typedef struct packed {
    logic        valid;
    logic        dec;
    logic [31:0] l;
    logic [31:0] r;
  } stage_t;

  localparam logic [6:0] IpTab [64] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7};

  localparam logic [6:0] FpTab [64] = '{
    7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
    7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
    7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
    7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
    7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
    7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
    7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
    7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25};

  localparam logic [5:0] ETab [48] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,
    6'd6,  6'd7,  6'd8,  6'd9,  6'd8,  6'd9,  6'd10, 6'd11,
    6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21,
    6'd22, 6'd23, 6'd24, 6'd25, 6'd24, 6'd25, 6'd26, 6'd27,
    6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1};

  localparam logic [5:0] PTab [32] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25};

  localparam logic [6:0] Pc1Tab [56] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
    7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
    7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
    7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
    7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
    7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
    7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4};

  localparam logic [5:0] Pc2Tab [48] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28,
    6'd15, 6'd6,  6'd21, 6'd10, 6'd23, 6'd19, 6'd12, 6'd4,
    6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40,
    6'd51, 6'd45, 6'd33, 6'd48, 6'd44, 6'd49, 6'd39, 6'd56,
    6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32};

  // total left rotation of both key halves after each round, modulo 28
  localparam logic [4:0] RotSum [16] = '{
    5'd1,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14,
    5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd0};

  localparam logic [3:0] SBox [8][64] = '{
    '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
      4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7,
      4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
      4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8,
      4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
      4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0,
      4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
      4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13},
    '{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
      4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10,
      4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
      4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5,
      4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
      4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15,
      4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
      4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9},
    '{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
      4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8,
      4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
      4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
      4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
      4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7,
      4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
      4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12},
    '{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
      4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15,
      4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
      4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9,
      4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
      4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4,
      4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
      4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14},
    '{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
      4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9,
      4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
      4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6,
      4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
      4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14,
      4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
      4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3},
    '{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
      4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11,
      4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
      4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8,
      4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
      4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6,
      4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
      4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13},
    '{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
      4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1,
      4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
      4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6,
      4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
      4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2,
      4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
      4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12},
    '{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
      4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7,
      4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
      4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2,
      4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
      4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8,
      4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
      4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}};

  // table positions count from 1 at the msb
  function automatic logic [63:0] init_perm(input logic [63:0] v);
    logic [63:0] res;
    res = '0;
    for (int i = 0; i < 64; i++) begin
      res[63-i] = v[64-int'(IpTab[i])];
    end
    return res;
  endfunction

  function automatic logic [63:0] final_perm(input logic [63:0] v);
    logic [63:0] res;
    res = '0;
    for (int i = 0; i < 64; i++) begin
      res[63-i] = v[64-int'(FpTab[i])];
    end
    return res;
  endfunction

  function automatic logic [55:0] pc1(input logic [63:0] v);
    logic [55:0] res;
    res = '0;
    for (int i = 0; i < 56; i++) begin
      res[55-i] = v[64-int'(Pc1Tab[i])];
    end
    return res;
  endfunction

  function automatic logic [47:0] pc2(input logic [55:0] v);
    logic [47:0] res;
    res = '0;
    for (int i = 0; i < 48; i++) begin
      res[47-i] = v[56-int'(Pc2Tab[i])];
    end
    return res;
  endfunction

  function automatic logic [27:0] rotl28(input logic [27:0] h, input logic [4:0] n);
    logic [55:0] dbl;
    dbl = {h, h} << n;
    return dbl[55:28];
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] r, input rkey_t k);
    logic [47:0] x;
    logic [5:0]  six;
    logic [31:0] s;
    logic [31:0] res;
    x = '0;
    s = '0;
    res = '0;
    for (int i = 0; i < 48; i++) begin
      x[47-i] = r[32-int'(ETab[i])];
    end
    x = x ^ k;
    for (int i = 0; i < 8; i++) begin
      six = x[47-6*i -: 6];
      s[31-4*i -: 4] = SBox[i][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) begin
      res[31-i] = s[32-int'(PTab[i])];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/des_block_cipher_top.sv =====
// des block cipher top level: key register, round cell chain, permutations
// depends on des_pkg, des_key_sched, des_round_cell, des_block_cipher_top_defines.svh
//
// A request (start high while busy is low) enters a chain of sixteen round
// cells, one cell per feistel round, each with its own stage register. A new
// request is taken every clock cycle; its result appears after the last cell
// on block_out_o with out_valid_o high for exactly one cycle; the receiver
// cannot stall, so the result must be captured in that cycle. The round keys
// are derived combinationally from the key register, which the user must write
// through the cfg channel (always ready) only while no block is in the chain;
// the block does not check it. busy is high while a key write is requested.
`default_nettype none

`include "des_block_cipher_top_defines.svh"

module des_block_cipher_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        command_i,
  input  wire logic [63:0] block_in_i,
  output logic             out_valid_o,
  output logic [63:0]      block_out_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [63:0] cfg_data_i
);

  logic [63:0]     key_q;
  logic [63:0]     ip_blk;
  logic            accept;
  des_pkg::rkey_t  rkey [des_pkg::NumRounds];
  des_pkg::stage_t chain [des_pkg::NumRounds + 1];

  assign cfg_ready_o = 1'b1;
  assign busy        = cfg_valid_i;
  assign accept      = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      key_q <= cfg_data_i;
    end
  end

  des_key_sched u_key_sched (
    .key_i  (key_q),
    .rkey_o (rkey)
  );

  assign ip_blk = des_pkg::init_perm(block_in_i);

  always_comb begin
    chain[0].valid = accept;
    chain[0].dec   = command_i;
    chain[0].l     = ip_blk[63:32];
    chain[0].r     = ip_blk[31:0];
  end

  for (genvar g = 0; g < des_pkg::NumRounds; g++) begin : g_cell
    des_round_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .stage_i    (chain[g]),
      .rkey_enc_i (rkey[g]),
      .rkey_dec_i (rkey[des_pkg::NumRounds - 1 - g]),
      .stage_o    (chain[g+1])
    );
  end

  // halves swap back before the final permutation
  assign out_valid_o = chain[des_pkg::NumRounds].valid;
  assign block_out_o = des_pkg::final_perm({chain[des_pkg::NumRounds].r,
                                            chain[des_pkg::NumRounds].l});

  `DES_ASSERT_IMP(a_result_has_request, out_valid_o, $past(start && !busy, 16))
  `DES_ASSERT_IMP(a_request_gives_result, start && !busy, ##16 out_valid_o)
  `DES_ASSERT_NXT(a_key_write_lands, cfg_valid_i, key_q == $past(cfg_data_i))

endmodule

`default_nettype wire

// ===== hw/rtl/des_key_sched.sv =====
// des key schedule: the sixteen round keys derived from the key register
// depends on des_pkg
`default_nettype none

module des_key_sched (
  input  wire logic [63:0]   key_i,
  output des_pkg::rkey_t     rkey_o [des_pkg::NumRounds]
);

  logic [55:0] k56;

  assign k56 = des_pkg::pc1(key_i);

  for (genvar g = 0; g < des_pkg::NumRounds; g++) begin : g_round
    assign rkey_o[g] = des_pkg::pc2({des_pkg::rotl28(k56[55:28], des_pkg::RotSum[g]),
                                     des_pkg::rotl28(k56[27:0],  des_pkg::RotSum[g])});
  end

endmodule

`default_nettype wire

// ===== hw/rtl/des_round_cell.sv =====
// des round cell: one feistel round with its stage register
// depends on des_pkg
`default_nettype none

module des_round_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire des_pkg::stage_t stage_i,
  input  wire des_pkg::rkey_t  rkey_enc_i,
  input  wire des_pkg::rkey_t  rkey_dec_i,
  output des_pkg::stage_t      stage_o
);

  des_pkg::rkey_t  rkey;
  des_pkg::stage_t stage_d;
  des_pkg::stage_t stage_q;

  assign rkey = stage_i.dec ? rkey_dec_i : rkey_enc_i;

  always_comb begin
    stage_d.valid = stage_i.valid;
    stage_d.dec   = stage_i.dec;
    stage_d.l     = stage_i.r;
    stage_d.r     = stage_i.l ^ des_pkg::feistel(stage_i.r, rkey);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

`default_nettype wire
